// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lpjd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpjd_pkg
// Types and constants shared by the length-prefixed deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpjd_pkg;

    localparam int BYTE_W        = 8;
    localparam int CLASS_W       = 3;
    localparam int ERR_W         = 3;
    localparam int LEN_W         = 40;
    localparam int CLEN_W        = 48;
    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 4;
    localparam int HEADER_DIGITS = 10;
    localparam int DIGIT_W       = $clog2(HEADER_DIGITS + 1);

    localparam logic [APB_ADDR_W-1:0] ADDR_CONTENT_LENGTH = '0;

    localparam logic [BYTE_W-1:0] CHAR_SEP = 8'h7C;

    localparam logic [CLASS_W-1:0] CLS_HEADER  = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_SEP     = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_JSON    = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_DATA    = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_DISCARD = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
    localparam logic [ERR_W-1:0] ERR_LENGTH  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_SEP = 3'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_HEX = 3'd3;
    localparam logic [ERR_W-1:0] ERR_EMPTY   = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [CLASS_W-1:0] byte_class;
        logic               last_of_json;
        logic [ERR_W-1:0]   error_code;
        logic [LEN_W-1:0]   payload_length;
    } lpjd_result_t;

endpackage

// ----- hw/rtl/lpjd_stream_if.sv -----
// ----------------------------------------------------------------------------
// lpjd_stream_if
// Valid/ready channels for raw body bytes and classified result bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpjd_in_if;
    logic                          valid;
    logic                          ready;
    logic [lpjd_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpjd_out_if;
    logic                          valid;
    logic                          ready;
    logic [lpjd_pkg::BYTE_W-1:0]   out_byte;
    logic [lpjd_pkg::CLASS_W-1:0]  byte_class;
    logic                          last_of_json;
    logic [lpjd_pkg::ERR_W-1:0]    error_code;
    logic [lpjd_pkg::LEN_W-1:0]    payload_length;

    modport source (output valid, output out_byte, output byte_class, output last_of_json,
                    output error_code, output payload_length, input ready);
    modport sink   (input valid, input out_byte, input byte_class, input last_of_json,
                    input error_code, input payload_length, output ready);
endinterface

// ----- hw/rtl/lpjd_parser.sv -----
// ----------------------------------------------------------------------------
// lpjd_parser
// Framing state machine: decodes the hex length header, checks the
// separator, counts payload bytes and classifies each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpjd_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [lpjd_pkg::BYTE_W-1:0]   data_byte,
    input  logic [lpjd_pkg::CLEN_W-1:0]   content_length,
    output lpjd_pkg::lpjd_result_t        result
);
    import lpjd_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SEP    = 3'd1;
    localparam logic [2:0] PH_JSON   = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_FAIL   = 3'd4;

    localparam logic [DIGIT_W-1:0] DIGITS_LAST = DIGIT_W'(HEADER_DIGITS - 1);
    localparam logic [DIGIT_W-1:0] DIGITS_FULL = DIGIT_W'(HEADER_DIGITS);
    localparam logic [CLEN_W-1:0]  FRAME_OVERHEAD = CLEN_W'(HEADER_DIGITS + 1);

    logic [2:0]         phase_reg;
    logic [2:0]         phase_next;
    logic [DIGIT_W-1:0] digit_count_reg;
    logic [DIGIT_W-1:0] digit_count_next;
    logic [LEN_W-1:0]   length_acc_reg;
    logic [LEN_W-1:0]   length_acc_next;
    logic [LEN_W-1:0]   bytes_left_reg;
    logic [LEN_W-1:0]   bytes_left_next;

    logic               hex_ok;
    logic [3:0]         hex_val;
    logic [LEN_W-1:0]   acc_shift;
    logic [CLEN_W-1:0]  frame_total;
    logic [CLASS_W-1:0] cls;
    logic               last;
    logic [ERR_W-1:0]   err;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
        begin
            hex_val = 4'(data_byte - 8'h30);
        end
        else if (data_byte >= 8'h61 && data_byte <= 8'h66)
        begin
            hex_val = 4'(data_byte - 8'h57);
        end
        else if (data_byte >= 8'h41 && data_byte <= 8'h46)
        begin
            hex_val = 4'(data_byte - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign acc_shift   = {length_acc_reg[LEN_W-5:0], hex_val};
    assign frame_total = {{(CLEN_W-LEN_W){1'b0}}, acc_shift} + FRAME_OVERHEAD;

    always_comb
    begin
        phase_next       = phase_reg;
        digit_count_next = digit_count_reg;
        length_acc_next  = length_acc_reg;
        bytes_left_next  = bytes_left_reg;
        cls              = CLS_HEADER;
        last             = 1'b0;
        err              = ERR_NONE;
        unique case (phase_reg)
            PH_HEADER:
            begin
                cls = CLS_HEADER;
                if (!hex_ok)
                begin
                    err        = ERR_BAD_HEX;
                    phase_next = PH_FAIL;
                end
                else
                begin
                    length_acc_next = acc_shift;
                    if (digit_count_reg >= DIGITS_LAST)
                    begin
                        digit_count_next = DIGITS_FULL;
                        phase_next       = PH_SEP;
                        if (frame_total > content_length)
                        begin
                            err = ERR_LENGTH;
                        end
                    end
                    else
                    begin
                        digit_count_next = digit_count_reg + 1'b1;
                    end
                end
            end
            PH_SEP:
            begin
                cls = CLS_SEP;
                if (data_byte != CHAR_SEP)
                begin
                    err        = ERR_BAD_SEP;
                    phase_next = PH_FAIL;
                end
                else if (length_acc_reg == '0)
                begin
                    err        = ERR_EMPTY;
                    phase_next = PH_DATA;
                end
                else
                begin
                    bytes_left_next = length_acc_reg;
                    phase_next      = PH_JSON;
                end
            end
            PH_JSON:
            begin
                cls = CLS_JSON;
                if (bytes_left_reg != '0)
                begin
                    bytes_left_next = bytes_left_reg - 1'b1;
                end
                if (bytes_left_next == '0)
                begin
                    last       = 1'b1;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                cls = CLS_DATA;
            end
            default:
            begin
                cls        = CLS_DISCARD;
                phase_next = PH_FAIL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            digit_count_reg <= '0;
            length_acc_reg  <= '0;
            bytes_left_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            digit_count_reg <= digit_count_next;
            length_acc_reg  <= length_acc_next;
            bytes_left_reg  <= bytes_left_next;
        end
    end

    always_comb
    begin
        result.out_byte       = data_byte;
        result.byte_class     = cls;
        result.last_of_json   = last;
        result.error_code     = err;
        result.payload_length = (digit_count_next == DIGITS_FULL) ? length_acc_next : '0;
    end

endmodule

// ----- hw/rtl/length_prefixed_json_deframer_core.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_json_deframer_core
// Splits a body stream into a hex length header, a separator, a json payload
// of the announced length and trailing data, one byte per cycle if unstalled.
// ----------------------------------------------------------------------------
// Usage:
//   din  : one raw body byte per transfer (valid/ready).
//   dout : one classified byte per transfer: out_byte, byte_class,
//          last_of_json, error_code, payload_length.
//   APB  : register content_length (48 bits) at byte address 0, 64-bit
//          data; write it only while no byte is in flight.
//   Each byte passes an input register and then a result register; dout
//   valid rises when the byte moves into the result register, which it can
//   only do while no stalled result is held there. The framing state advances
//   once per byte, so one byte is taken every cycle unless dout stalls.
//   Reset returns the framer to the header phase, clears the length
//   and content_length, and empties both registers.
//   When dout stalls, the result register holds and the input register
//   still takes one more byte; din ready falls once both are full and
//   rises in the cycle dout is taken again. No byte is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module length_prefixed_json_deframer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    lpjd_in_if.sink                            din,
    lpjd_out_if.source                         dout,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpjd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lpjd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lpjd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import lpjd_pkg::*;

    logic [CLEN_W-1:0]  content_length_reg;
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg;
    lpjd_result_t       out_reg;
    lpjd_result_t       result;
    logic               advance;
    logic               in_xfer;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CONTENT_LENGTH)
                  ? {{(APB_DATA_W-CLEN_W){1'b0}}, content_length_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            content_length_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_CONTENT_LENGTH)
        begin
            content_length_reg <= pwdata[CLEN_W-1:0];
        end
    end

    assign advance   = in_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready = !in_valid_reg || advance;
    assign in_xfer   = din.valid && din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= din.data_byte;
        end
    end

    lpjd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .data_byte      (in_byte_reg),
        .content_length (content_length_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign dout.valid          = out_valid_reg;
    assign dout.out_byte       = out_reg.out_byte;
    assign dout.byte_class     = out_reg.byte_class;
    assign dout.last_of_json   = out_reg.last_of_json;
    assign dout.error_code     = out_reg.error_code;
    assign dout.payload_length = out_reg.payload_length;

    `ASSERT_ALWAYS(a_no_drop_on_stall, !(in_valid_reg && out_valid_reg && !dout.ready && din.ready), "input taken while both stages are full and output stalls")
    `ASSERT_IMPLIES(a_last_is_json, out_valid_reg && out_reg.last_of_json, out_reg.byte_class == CLS_JSON, "last_of_json outside json payload")
    `ASSERT_IMPLIES(a_json_has_length, out_valid_reg && out_reg.byte_class == CLS_JSON, out_reg.payload_length != '0, "json payload byte with zero decoded length")
    `ASSERT_IMPLIES(a_discard_clean, out_valid_reg && out_reg.byte_class == CLS_DISCARD, out_reg.error_code == ERR_NONE && !out_reg.last_of_json, "discarded byte carries flags")

endmodule

// ----- tb/tb_length_prefixed_json_deframer_core.sv -----
// ----------------------------------------------------------------------------
// tb_length_prefixed_json_deframer_core
// Drives one body stream through the deframer and checks every classified
// byte against a cycle-free model of the framing rules. The stream shape
// (framed, oversized, empty, bad separator, bad hex digit) is drawn from
// the seed, since only reset leaves the failure phase. content_length is
// written and read back over APB between phases, both sides idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_length_prefixed_json_deframer_core;

    import lpjd_pkg::*;

    localparam int          TOTAL_ITEMS   = 750;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          IDLE_LIMIT    = 3000;
    localparam int          CFG_SPACING   = 150;
    localparam logic [47:0] CLEN_MAX      = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        FR_HEADER,
        FR_SEP,
        FR_JSON,
        FR_DATA,
        FR_FAIL
    } frame_phase_e;

    typedef enum logic [2:0] {
        SC_FRAMED,
        SC_HUGE,
        SC_EMPTY,
        SC_BAD_SEP,
        SC_BAD_HEX
    } stream_shape_e;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    lpjd_in_if  din_if();
    lpjd_out_if dout_if();

    length_prefixed_json_deframer_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // framing model state
    frame_phase_e  fr_phase;
    int            fr_digits;
    logic [39:0]   fr_acc;
    logic [39:0]   fr_bytes_left;
    logic [47:0]   fr_content_length;

    lpjd_result_t  pending_classified[$];

    stream_shape_e shape;
    logic [39:0]   announced_len;
    int            bytes_sent;
    int            results_checked;
    int            mismatch_count;
    int            reg_writes;
    int            hold_offs;
    bit            send_smooth;
    bit            hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66)
            return {1'b0, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46)
            return {1'b0, 4'(c - 8'h41 + 8'd10)};
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic lpjd_result_t deframe_byte(logic [7:0] b);
        lpjd_result_t r;
        logic [4:0]   nib;
        r.out_byte     = b;
        r.byte_class   = CLS_HEADER;
        r.last_of_json = 1'b0;
        r.error_code   = ERR_NONE;
        case (fr_phase)
            FR_HEADER:
            begin
                nib = hex_nibble(b);
                if (nib[4])
                begin
                    r.error_code = ERR_BAD_HEX;
                    fr_phase     = FR_FAIL;
                end
                else
                begin
                    fr_acc    = {fr_acc[35:0], nib[3:0]};
                    fr_digits = fr_digits + 1;
                    if (fr_digits >= HEADER_DIGITS)
                    begin
                        fr_digits = HEADER_DIGITS;
                        if (({24'b0, fr_acc} + 64'(HEADER_DIGITS + 1)) >
                            {16'b0, fr_content_length})
                            r.error_code = ERR_LENGTH;
                        fr_phase = FR_SEP;
                    end
                end
            end
            FR_SEP:
            begin
                r.byte_class = CLS_SEP;
                if (b != CHAR_SEP)
                begin
                    r.error_code = ERR_BAD_SEP;
                    fr_phase     = FR_FAIL;
                end
                else if (fr_acc == '0)
                begin
                    r.error_code = ERR_EMPTY;
                    fr_phase     = FR_DATA;
                end
                else
                begin
                    fr_bytes_left = fr_acc;
                    fr_phase      = FR_JSON;
                end
            end
            FR_JSON:
            begin
                r.byte_class = CLS_JSON;
                if (fr_bytes_left != '0)
                    fr_bytes_left = fr_bytes_left - 40'd1;
                if (fr_bytes_left == '0)
                begin
                    r.last_of_json = 1'b1;
                    fr_phase       = FR_DATA;
                end
            end
            FR_DATA:
                r.byte_class = CLS_DATA;
            default:
            begin
                r.byte_class = CLS_DISCARD;
                fr_phase     = FR_FAIL;
            end
        endcase
        r.payload_length = (fr_digits >= HEADER_DIGITS) ? fr_acc : '0;
        return r;
    endfunction

    function automatic int next_gap(bit smooth);
        int r;
        if (smooth)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] random_clen();
        return 48'({$urandom, $urandom});
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        din_if.valid     <= 1'b1;
        din_if.data_byte <= b;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        pending_classified.push_back(deframe_byte(b));
        bytes_sent = bytes_sent + 1;
        @(negedge clk);
        if ($urandom_range(0, 39) == 0)
            send_smooth = ~send_smooth;
        gap = next_gap(send_smooth);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic apb_access(bit wr, logic [63:0] wdata, output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_CONTENT_LENGTH;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // drain, then write content_length and read it back
    task automatic set_content_length(logic [63:0] value);
        logic [63:0] rd;
        din_if.valid <= 1'b0;
        while (pending_classified.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        apb_access(1'b1, value, rd);
        fr_content_length = value[47:0];
        reg_writes        = reg_writes + 1;
        apb_access(1'b0, '0, rd);
        if (rd != {16'b0, value[47:0]})
        begin
            mismatch_count = mismatch_count + 1;
            $display("%0t content_length readback: expected %h actual %h",
                     $time, {16'b0, value[47:0]}, rd);
        end
    endtask

    task automatic test_register_access();
        int pick;
        set_content_length(64'd0);
        set_content_length(64'hFFFF_FFFF_FFFF_FFFF);
        set_content_length(64'h0000_8000_0000_0001);
        pick = $urandom_range(0, 4);
        case (pick)
            0:       set_content_length(64'd0);
            1:       set_content_length({16'b0, CLEN_MAX});
            2:       set_content_length(64'(announced_len) + 64'd10);
            3:       set_content_length(64'(announced_len) + 64'd11);
            default: set_content_length({16'b0, random_clen()});
        endcase
    endtask

    task automatic test_length_header();
        logic [7:0] bad_chars[12];
        logic [7:0] bad;
        logic [4:0] nib;
        int         bad_pos;
        int         idx;
        bad_chars = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67,
                      8'h20, 8'h2B, 8'h78, CHAR_SEP, 8'h00, 8'hFF};
        bad_pos = (shape == SC_BAD_HEX) ? $urandom_range(0, HEADER_DIGITS - 1) : HEADER_DIGITS;
        for (int d = 0; d < HEADER_DIGITS; d++)
        begin
            if (d == bad_pos)
            begin
                idx = $urandom_range(0, 12);
                if (idx < 12)
                    bad = bad_chars[idx];
                else
                begin
                    bad = 8'($urandom_range(0, 255));
                    nib = hex_nibble(bad);
                    while (!nib[4])
                    begin
                        bad = 8'($urandom_range(0, 255));
                        nib = hex_nibble(bad);
                    end
                end
                send_byte(bad);
            end
            else
                send_byte(hex_char(announced_len[4*(HEADER_DIGITS-1-d) +: 4],
                                   1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_separator();
        logic [7:0] b;
        if (shape == SC_BAD_SEP)
        begin
            case ($urandom_range(0, 3))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = 8'h7B;
                default: b = 8'($urandom_range(0, 255));
            endcase
            if (b == CHAR_SEP)
                b = 8'h7D;
            send_byte(b);
        end
        else
            send_byte(CHAR_SEP);
    endtask

    task automatic test_payload_edges();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_SEP);
        send_byte(8'h7B);
        send_byte(8'h7D);
        send_byte(8'h80);
        send_byte(8'h7F);
    endtask

    task automatic test_back_pressure();
        hold_req = 1'b1;
        hold_offs = hold_offs + 1;
        repeat (40)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_stream();
        int since_cfg;
        since_cfg = 0;
        while (bytes_sent < TOTAL_ITEMS)
        begin
            if (since_cfg >= CFG_SPACING)
            begin
                case ($urandom_range(0, 2))
                    0:       set_content_length(64'd0);
                    1:       set_content_length({16'b0, CLEN_MAX});
                    default: set_content_length({16'b0, random_clen()});
                endcase
                since_cfg = 0;
            end
            send_byte(8'($urandom_range(0, 255)));
            since_cfg = since_cfg + 1;
        end
        din_if.valid <= 1'b0;
    endtask

    // receiver: random gaps, smooth stretches, one long hold-off on request
    initial
    begin : sink_proc
        int  hold_left;
        int  sink_gap;
        bit  sink_smooth;
        hold_left      = 0;
        sink_gap       = 0;
        sink_smooth    = 1'b0;
        dout_if.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                dout_if.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (sink_gap > 0)
            begin
                dout_if.ready <= 1'b0;
                sink_gap = sink_gap - 1;
            end
            else
            begin
                dout_if.ready <= 1'b1;
                sink_gap = next_gap(sink_smooth);
                if ($urandom_range(0, 63) == 0)
                    sink_smooth = ~sink_smooth;
            end
        end
    end

    initial
    begin : check_proc
        lpjd_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && dout_if.valid && dout_if.ready)
            begin
                if (pending_classified.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    $display("%0t unexpected transfer: expected none actual byte %h class %0d",
                             $time, dout_if.out_byte, dout_if.byte_class);
                end
                else
                begin
                    exp_r = pending_classified.pop_front();
                    results_checked = results_checked + 1;
                    if (dout_if.out_byte !== exp_r.out_byte)
                    begin
                        mismatch_count = mismatch_count + 1;
                        $display("%0t out_byte: expected %h actual %h",
                                 $time, exp_r.out_byte, dout_if.out_byte);
                    end
                    if (dout_if.byte_class !== exp_r.byte_class)
                    begin
                        mismatch_count = mismatch_count + 1;
                        $display("%0t byte_class: expected %0d actual %0d",
                                 $time, exp_r.byte_class, dout_if.byte_class);
                    end
                    if (dout_if.last_of_json !== exp_r.last_of_json)
                    begin
                        mismatch_count = mismatch_count + 1;
                        $display("%0t last_of_json: expected %b actual %b",
                                 $time, exp_r.last_of_json, dout_if.last_of_json);
                    end
                    if (dout_if.error_code !== exp_r.error_code)
                    begin
                        mismatch_count = mismatch_count + 1;
                        $display("%0t error_code: expected %0d actual %0d",
                                 $time, exp_r.error_code, dout_if.error_code);
                    end
                    if (dout_if.payload_length !== exp_r.payload_length)
                    begin
                        mismatch_count = mismatch_count + 1;
                        $display("%0t payload_length: expected %h actual %h",
                                 $time, exp_r.payload_length, dout_if.payload_length);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog_proc
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t no transfer for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending_classified.size());
                $display("[length_prefixed_json_deframer_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : main_proc
        int r;
        rst_n            <= 1'b0;
        din_if.valid     <= 1'b0;
        din_if.data_byte <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        fr_phase          = FR_HEADER;
        fr_digits         = 0;
        fr_acc            = '0;
        fr_bytes_left     = '0;
        fr_content_length = '0;
        bytes_sent        = 0;
        results_checked   = 0;
        mismatch_count    = 0;
        reg_writes        = 0;
        hold_offs         = 0;
        send_smooth       = 1'b0;
        hold_req          = 1'b0;

        r = $urandom_range(0, 9);
        case (r)
            0:       shape = SC_BAD_HEX;
            1:       shape = SC_BAD_SEP;
            2:       shape = SC_EMPTY;
            3:       shape = SC_HUGE;
            default: shape = SC_FRAMED;
        endcase
        case (shape)
            SC_FRAMED:
                announced_len = ($urandom_range(0, 9) == 0) ? 40'd1 :
                                40'($urandom_range(2, 400));
            SC_HUGE:
                announced_len = ($urandom_range(0, 1) == 0) ? 40'hFF_FFFF_FFFF :
                                (40'({$urandom, $urandom}) | 40'h80_0000_0000);
            SC_EMPTY:
                announced_len = '0;
            default:
                announced_len = ($urandom_range(0, 1) == 0) ? 40'($urandom_range(1, 400)) :
                                40'({$urandom, $urandom});
        endcase

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_access();
        test_length_header();
        test_separator();
        test_payload_edges();
        set_content_length({16'b0, random_clen()});
        test_back_pressure();
        test_random_stream();

        while (pending_classified.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("stream shape %s, announced length %0d: %0d bytes sent, %0d results checked",
                 shape.name(), announced_len, bytes_sent, results_checked);
        $display("%0d content_length writes with readback, %0d long receiver hold-offs",
                 reg_writes, hold_offs);
        if (mismatch_count == 0 && pending_classified.size() == 0)
            $display("[length_prefixed_json_deframer_core] OK");
        else
            $display("[length_prefixed_json_deframer_core] ERROR");
        $finish;
    end

endmodule

// ----- length_prefixed_json_deframer_core.f -----
+incdir+hw/rtl
hw/rtl/lpjd_pkg.sv
hw/rtl/lpjd_stream_if.sv
hw/rtl/lpjd_parser.sv
hw/rtl/length_prefixed_json_deframer_core.sv
tb/tb_length_prefixed_json_deframer_core.sv
